// ===== rtl/ccsk_psk_symbol_metric_defines.svh =====
// ----------------------------------------------------------------------------
// ccsk_psk_symbol_metric defines
// assertion macros shared by the symbol metric block
// ----------------------------------------------------------------------------
`ifndef CCSK_PSK_SYMBOL_METRIC_DEFINES_SVH
`define CCSK_PSK_SYMBOL_METRIC_DEFINES_SVH

// a condition implies a consequence in the same cycle
`define CPSM_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// a condition implies a consequence in the next cycle
`define CPSM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/cpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsm_pkg
// types, constants and the constellation table of the symbol metric block
// ----------------------------------------------------------------------------
package cpsm_pkg;

   localparam int SYMBOLS_DEF = 64;
   localparam int CHIPS_DEF   = 64;
   localparam int DIST_W      = 48;
   localparam int METRIC_W    = 24;
   localparam logic [15:0] INV_TWO_VAR_RST = 16'd256;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [5:0]         code_row;
      logic [5:0]         chip_index;
      logic [5:0]         phase;
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
   } req_type;

   typedef struct packed {
      logic [5:0]          symbol;
      logic [METRIC_W-1:0] metric;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACC, ST_FETCH, ST_SCALE, ST_MUL, ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_sum;     // start a new row sum
      logic acc_en;      // add the chip term now in the read registers
      logic row_done;    // store the finished row sum and update minimum
      logic clr_min;
      logic mul_load;    // latch the difference for the current row
      logic mul_en;      // register the product
      logic out_load;    // move the metric to the output register
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic out_full;
   } sts_type;

   function automatic logic signed [15:0] sine_of(input logic [5:0] p);
      logic [14:0] qs [0:16];
      logic [4:0]  r;
      logic [14:0] v;
      qs = '{15'd0, 15'd803, 15'd1598, 15'd2378, 15'd3135, 15'd3862, 15'd4551,
             15'd5197, 15'd5793, 15'd6333, 15'd6811, 15'd7225, 15'd7568,
             15'd7839, 15'd8035, 15'd8153, 15'd8192};
      r = {1'b0, p[3:0]};
      v = p[4] ? qs[5'd16 - r] : qs[r];
      return p[5] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

// ===== rtl/cpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpsm_ctrl
// sequencer: walks rows and chips for the sums, then rows for the metrics
// ----------------------------------------------------------------------------
module cpsm_ctrl #(
   parameter int SYMBOLS = cpsm_pkg::SYMBOLS_DEF,
   parameter int CHIPS   = cpsm_pkg::CHIPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cpsm_pkg::sts_type  sts,
   input  logic               out_take,
   output logic               busy,
   output logic [5:0]         row,
   output logic [5:0]         chip,
   output logic               rd_valid,
   output cpsm_pkg::cmd_type  cmd
);
   cpsm_pkg::state_type state_ff, state_in;
   logic [6:0] row_ff, row_in;    // one bit wider to mark all rows issued
   logic [5:0] chip_ff, chip_in;
   logic       rd_ff, rd_in;   // read issued last cycle
   logic       lst_ff, lst_in; // last chip of a row issued last cycle

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      chip_in  = chip_ff;
      rd_in    = 1'b0;
      lst_in   = 1'b0;
      case (state_ff)
         cpsm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = cpsm_pkg::ST_ACC;
               row_in   = '0;
               chip_in  = '0;
            end
         end
         cpsm_pkg::ST_ACC: begin
            // reads issued row by row; leave once the last read has cleared the read registers
            if (row_ff != 7'(SYMBOLS)) begin
               rd_in  = 1'b1;
               lst_in = (chip_ff == 6'(CHIPS - 1));
               if (chip_ff == 6'(CHIPS - 1)) begin
                  chip_in = '0;
                  row_in  = row_ff + 7'd1;
               end else begin
                  chip_in = chip_ff + 6'd1;
               end
            end else if (!rd_ff && !lst_ff) begin
               state_in = cpsm_pkg::ST_FETCH;
               row_in   = '0;
            end
         end
         // distance memory read for the current row
         cpsm_pkg::ST_FETCH: state_in = cpsm_pkg::ST_SCALE;
         cpsm_pkg::ST_SCALE: state_in = cpsm_pkg::ST_MUL;
         cpsm_pkg::ST_MUL:   state_in = cpsm_pkg::ST_EMIT;
         cpsm_pkg::ST_EMIT: begin
            if (!sts.out_full || out_take) begin
               if (row_ff == 7'(SYMBOLS - 1)) begin
                  state_in = cpsm_pkg::ST_IDLE;
               end else begin
                  row_in   = row_ff + 7'd1;
                  state_in = cpsm_pkg::ST_FETCH;
               end
            end
         end
         default: state_in = cpsm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.clr_min  = (state_ff == cpsm_pkg::ST_IDLE) && start;
      cmd.acc_en   = rd_ff;
      cmd.row_done = lst_ff;
      cmd.clr_sum  = lst_ff || cmd.clr_min;
      cmd.mul_load = (state_ff == cpsm_pkg::ST_SCALE);
      cmd.mul_en   = (state_ff == cpsm_pkg::ST_MUL);
      cmd.out_load = (state_ff == cpsm_pkg::ST_EMIT) && (!sts.out_full || out_take);
   end

   assign busy     = (state_ff != cpsm_pkg::ST_IDLE);
   assign row      = row_ff[5:0];
   assign chip     = chip_ff;
   assign rd_valid = rd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpsm_pkg::ST_IDLE;
         rd_ff    <= 1'b0;
         lst_ff   <= 1'b0;
         row_ff   <= '0;
         chip_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
         lst_ff   <= lst_in;
         row_ff   <= row_in;
         chip_ff  <= chip_in;
      end
   end
endmodule

// ===== rtl/cpsm_dp.sv =====
// ----------------------------------------------------------------------------
// cpsm_dp
// datapath: codebook and chip memories, distance accumulator, scaling
// ----------------------------------------------------------------------------
module cpsm_dp #(
   parameter int SYMBOLS = cpsm_pkg::SYMBOLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cb_we,
   input  logic                smp_we,
   input  cpsm_pkg::req_type   req,
   input  logic [15:0]         inv_two_var,
   input  logic [5:0]          row,
   input  logic [5:0]          chip,
   input  logic                rd_valid,
   input  cpsm_pkg::cmd_type   cmd,
   input  logic                out_take,
   output cpsm_pkg::sts_type   sts,
   output logic                out_valid,
   output cpsm_pkg::rsp_type   out_data
);
   localparam int DW = cpsm_pkg::DIST_W;

   logic [5:0]  cb_mem  [0:4095];
   logic [31:0] smp_mem [0:63];
   logic [DW-1:0] dist_mem [0:63];

   logic [5:0]  phase_ff;
   logic [31:0] smp_ff;
   logic [DW-1:0] sum_ff, sum_in, min_ff, dist_rd_ff;
   logic [5:0]  wr_row_ff;
   logic [DW-1:0] diff_ff;
   logic [DW+15:0] prod_ff;
   logic        out_valid_ff;
   cpsm_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (cb_we) cb_mem[{req.code_row, req.chip_index}] <= req.phase;
      if (smp_we) smp_mem[req.chip_index] <= {req.sample_q, req.sample_i};
      if (rd_valid) begin
         phase_ff <= cb_mem[{row, chip}];
         smp_ff   <= smp_mem[chip];
      end
      if (cmd.row_done) dist_mem[wr_row_ff] <= sum_in;
      dist_rd_ff <= dist_mem[row];
   end

   // one chip term: squared distances on I and Q
   logic signed [15:0] pt_i, pt_q;
   logic signed [16:0] di, dq;
   logic signed [33:0] sq_i, sq_q;
   logic [33:0] term;
   always_comb begin
      pt_i = cpsm_pkg::sine_of(phase_ff);
      pt_q = cpsm_pkg::sine_of(phase_ff + 6'd16);
      di   = 17'(signed'(smp_ff[15:0])) - 17'(pt_i);
      dq   = 17'(signed'(smp_ff[31:16])) - 17'(pt_q);
      sq_i = di * di;
      sq_q = dq * dq;
      term = unsigned'(sq_i) + unsigned'(sq_q);
      sum_in = sum_ff + (cmd.acc_en ? DW'(term) : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_sum) sum_ff <= '0;
      else             sum_ff <= sum_in;
      if (cmd.clr_min) min_ff <= '1;
      else if (cmd.row_done && sum_in < min_ff) min_ff <= sum_in;
      if (cmd.clr_min) wr_row_ff <= '0;
      else if (cmd.row_done) wr_row_ff <= wr_row_ff + 6'd1;
      if (cmd.mul_load) diff_ff <= dist_rd_ff - min_ff;
      if (cmd.mul_en) prod_ff <= diff_ff * inv_two_var + (DW+16)'(1) * (1 << 25);
   end

   // rounding add folded into the product register; saturate after shift
   logic [DW-11:0] shifted;
   logic [23:0] metric;
   assign shifted = prod_ff[DW+15:26];
   assign metric  = (|shifted[DW-11:24]) ? '1 : shifted[23:0];

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (out_take) out_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         out_ff.symbol <= row;
         out_ff.metric <= metric;
         out_ff.last   <= (row == 6'(SYMBOLS - 1));
      end
   end

   assign sts.out_full = out_valid_ff;
   assign out_valid    = out_valid_ff;
   assign out_data     = out_ff;
endmodule

// ===== rtl/ccsk_psk_symbol_metric.sv =====
// ----------------------------------------------------------------------------
// ccsk_psk_symbol_metric
// soft demapper for cyclic code shift keying over 64-psk
// ----------------------------------------------------------------------------
// loads and samples are written while idle; the final chip starts a run
// run: a sum per row over all chips (one chip term a cycle), then per metric
// read, subtract, multiply, emit; emit waits while the output register is full
// input stall is high for the whole run; results wait in an output register
// reset: synchronous, active high; inv_two_var returns to 1.0, memories keep data
module ccsk_psk_symbol_metric #(
   parameter int SYMBOLS = cpsm_pkg::SYMBOLS_DEF,
   parameter int CHIPS   = cpsm_pkg::CHIPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpsm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
`include "ccsk_psk_symbol_metric_defines.svh"

   logic [15:0] inv_ff;
   logic busy, acc, cb_we, smp_we, start, take, rd_valid;
   logic [5:0] row, chip;
   cpsm_pkg::cmd_type cmd;
   cpsm_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) inv_ff <= cpsm_pkg::INV_TWO_VAR_RST;
      else if (csr_we) inv_ff <= csr_wdata;
   end

   assign req_stall = busy;
   assign acc    = req_valid && !busy;
   assign cb_we  = acc && req_data.operation == cpsm_pkg::OP_LOAD
                   && {1'b0, req_data.code_row} < 7'(SYMBOLS)
                   && {1'b0, req_data.chip_index} < 7'(CHIPS);
   assign smp_we = acc && req_data.operation == cpsm_pkg::OP_SAMPLE
                   && {1'b0, req_data.chip_index} < 7'(CHIPS);
   assign start  = smp_we && req_data.chip_index == 6'(CHIPS - 1);
   assign take   = rsp_valid && !rsp_stall;

   cpsm_ctrl #(.SYMBOLS(SYMBOLS), .CHIPS(CHIPS)) u_ctrl (
      .clock, .reset, .start, .sts, .out_take(take), .busy, .row, .chip,
      .rd_valid, .cmd
   );

   cpsm_dp #(.SYMBOLS(SYMBOLS)) u_dp (
      .clock, .reset, .cb_we, .smp_we, .req(req_data), .inv_two_var(inv_ff),
      .row, .chip, .rd_valid, .cmd, .out_take(take), .sts,
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

   `CPSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CPSM_ASSERT_NEXT(a_start_busy, clock, reset, start, busy)
   `CPSM_ASSERT_IMPL(a_load_no_out, clock, reset, cmd.out_load, busy)
endmodule
